@@ design/psps_pkg.sv @@
package psps_pkg;

  // Result status codes
  localparam logic [3:0] ST_BUSY        = 4'd0;
  localparam logic [3:0] ST_OK          = 4'd1;
  localparam logic [3:0] ST_NO_RESPONSE = 4'd2;
  localparam logic [3:0] ST_PAPER_OUT   = 4'd3;
  localparam logic [3:0] ST_LABEL_LEFT  = 4'd4;
  localparam logic [3:0] ST_RESTARTED   = 4'd5;
  localparam logic [3:0] ST_NO_PAPER    = 4'd6;
  localparam logic [3:0] ST_HEAP        = 4'd7;
  localparam logic [3:0] ST_PARAMETER   = 4'd8;
  localparam logic [3:0] ST_BUTTON      = 4'd9;
  localparam logic [3:0] ST_HEAD_LIFTED = 4'd10;

  // Configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_END_1ST  = 2'd1;
  localparam logic [1:0] CFG_END_2ND  = 2'd2;

  // Register reset values
  localparam logic [15:0] TIMEOUT_RST = 16'd100;
  localparam logic [7:0]  END_1ST_RST = 8'd10;
  localparam logic [7:0]  END_2ND_RST = 8'd48;

  localparam logic [7:0]  CHAR_ONE    = 8'h31;   // ASCII '1'
  localparam logic [15:0] TICKS_MAX   = 16'hFFFF;
  localparam int          FLAG_W      = 8;

  // Query number field: 0 = nothing to send
  localparam logic [2:0] SQ_NONE = 3'd0;

  typedef logic [1:0] query_t;    // query 1..4 held as 0..3

  typedef enum logic [7:0] {
    PH_SEND1 = 8'b0000_0001,
    PH_SEND2 = 8'b0000_0010,
    PH_SEND3 = 8'b0000_0100,
    PH_SEND4 = 8'b0000_1000,
    PH_WAIT1 = 8'b0001_0000,
    PH_WAIT2 = 8'b0010_0000,
    PH_WAIT3 = 8'b0100_0000,
    PH_WAIT4 = 8'b1000_0000
  } phase_t;

endpackage

@@ design/psps_decode.sv @@
module psps_decode (
  input  psps_pkg::query_t   query,
  input  logic [7:0]         flags,
  output logic [3:0]         code
);
  import psps_pkg::*;

  // First matching fault position wins; with no fault the code is busy (zero), or ok for query four
  always_comb begin
    code = ST_BUSY;
    unique case (query)
      2'd0: begin
        priority if (flags[0]) code = ST_PAPER_OUT;
        else if (flags[1])     code = ST_LABEL_LEFT;
        else if (flags[2])     code = ST_RESTARTED;
        else if (flags[3])     code = ST_NO_PAPER;
        else if (flags[7])     code = ST_HEAP;
        else                   code = ST_BUSY;
      end
      2'd1: code = ST_BUSY;
      2'd2: begin
        priority if (flags[2]) code = ST_PARAMETER;
        else if (flags[4])     code = ST_BUTTON;
        else                   code = ST_BUSY;
      end
      2'd3: begin
        priority if (flags[0]) code = ST_PAPER_OUT;
        else if (flags[1])     code = ST_LABEL_LEFT;
        else if (flags[3])     code = ST_HEAD_LIFTED;
        else if (flags[4])     code = ST_BUTTON;
        else if (flags[6])     code = ST_RESTARTED;
        else                   code = ST_OK;
      end
      default: code = ST_BUSY;
    endcase
  end

endmodule

@@ design/printer_status_poll_sequencer.sv @@
// Status poll sequencer for a serial label printer.
//
// Input stream: one transfer per event. in_tuser = 1 carries a received
// reply byte in in_tdata, in_tuser = 0 is a time tick (in_tdata ignored).
// Output stream: exactly one transfer per input transfer, in order.
// out_tdata[2:0] is the query to transmit now (0 = none), out_tdata[6:3]
// is the status code (0 busy, 1 ok, 2 no response, 3..10 faults).
// Config port: cfg_we/cfg_addr/cfg_wdata write timeout_ticks (0),
// first end char (1), second end char (2); write only while idle.
//
// Path: the input transfer is captured in the input register, then decoded
// into the result register, which drives the output transfer.
// Throughput is one transfer per cycle while the receiver does not stall.
// Reset (rst_n low, synchronous) empties both stages, restores register
// defaults and restarts the poll cycle at query one.
// When the receiver stalls the result holds and the input register still
// fills, so one more input transfer is taken before in_tready drops.
module printer_status_poll_sequencer #(
  parameter int FRAME_MAX = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        in_tuser,    // [0] func: 1 byte, 0 tick
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [2:0] send_query, [6:3] status_code, [7] zero
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import psps_pkg::*;

  localparam int CNT_W = $clog2(FRAME_MAX + 1);

  // config registers
  logic [15:0] timeout_r;
  logic [7:0]  end_1st_r;
  logic [7:0]  end_2nd_r;

  // input stage
  logic        s1_valid_r;
  logic        s1_func_r;
  logic [7:0]  s1_byte_r;

  // sequencer state
  phase_t      phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  // result stage
  logic        out_valid_r;
  logic [2:0]  send_r, send_nxt;
  logic [3:0]  status_r, status_nxt;

  logic        s1_adv;
  logic        is_send;
  query_t      query;
  phase_t      send_next_ph;
  phase_t      wait_ph;
  logic [3:0]  dec_code;
  logic        end_hit;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      end_1st_r <= END_1ST_RST;
      end_2nd_r <= END_2ND_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_END_1ST: end_1st_r <= cfg_wdata[7:0];
        CFG_END_2ND: end_2nd_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_func_r <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  // phase decode: send step flag, query index, follow-on phases
  always_comb begin
    is_send      = 1'b0;
    query        = 2'd0;
    wait_ph      = PH_WAIT1;
    send_next_ph = PH_SEND2;
    unique case (phase_r)
      PH_SEND1: begin is_send = 1'b1; query = 2'd0; wait_ph = PH_WAIT1; end
      PH_SEND2: begin is_send = 1'b1; query = 2'd1; wait_ph = PH_WAIT2; end
      PH_SEND3: begin is_send = 1'b1; query = 2'd2; wait_ph = PH_WAIT3; end
      PH_SEND4: begin is_send = 1'b1; query = 2'd3; wait_ph = PH_WAIT4; end
      PH_WAIT1: begin query = 2'd0; send_next_ph = PH_SEND2; end
      PH_WAIT2: begin query = 2'd1; send_next_ph = PH_SEND3; end
      PH_WAIT3: begin query = 2'd2; send_next_ph = PH_SEND4; end
      // query four never decodes to zero, so its follow-on send phase is not used
      PH_WAIT4: begin query = 2'd3; send_next_ph = PH_SEND1; end
      default: ;
    endcase
  end

  // flags updated with the current byte, then decoded (end byte counts)
  always_comb begin
    flags_nxt = flags_r;
    if (count_r < CNT_W'(FLAG_W) && s1_byte_r == CHAR_ONE) begin
      flags_nxt[count_r[2:0]] = 1'b1;
    end
  end

  psps_decode u_decode (
    .query (query),
    .flags (flags_nxt),
    .code  (dec_code)
  );

  assign end_hit = (s1_byte_r == end_1st_r) || (s1_byte_r == end_2nd_r);

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    ticks_nxt  = ticks_r;
    send_nxt   = SQ_NONE;
    status_nxt = ST_BUSY;
    if (is_send) begin
      // flush: the item itself is dropped, frame state cleared
      send_nxt  = {1'b0, query} + 3'd1;
      count_nxt = '0;
      ticks_nxt = '0;
      phase_nxt = wait_ph;
    end else if (!s1_func_r) begin
      if (ticks_r != TICKS_MAX) ticks_nxt = ticks_r + 16'd1;
      if (ticks_nxt > timeout_r) begin
        status_nxt = ST_NO_RESPONSE;
        phase_nxt  = PH_SEND1;
      end
    end else if (count_r >= CNT_W'(FRAME_MAX)) begin
      // over-long frame
      status_nxt = ST_NO_RESPONSE;
      phase_nxt  = PH_SEND1;
    end else begin
      count_nxt = count_r + CNT_W'(1);
      if (end_hit) begin
        if (dec_code != ST_BUSY) begin
          status_nxt = dec_code;
          phase_nxt  = PH_SEND1;
        end else begin
          phase_nxt  = send_next_ph;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEND1;
      count_r <= '0;
      flags_r <= '0;
      ticks_r <= '0;
    end else if (s1_adv) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      ticks_r <= ticks_nxt;
      if (is_send) begin
        flags_r <= '0;
      end else if (s1_func_r && count_r < CNT_W'(FRAME_MAX)) begin
        flags_r <= flags_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      send_r   <= send_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, status_r, send_r};

endmodule

@@ design/psps_checker.sv @@
module psps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7])
    else $error("pad bit set");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'd4 && out_tdata[6:3] <= 4'd10)
    else $error("result field out of range");

  // a send step never carries a status
  a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != 3'd0 |-> out_tdata[6:3] == 4'd0)
    else $error("status reported on send step");

endmodule

bind printer_status_poll_sequencer psps_checker u_psps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
